/* hw/rtl/keyed_slot_table_lookup_or_allocate_core_assert.svh */
// ----------------------------------------------------------------------------
// Keyed slot table assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_LOOKUP_OR_ALLOCATE_CORE_ASSERT_SVH
`define KEYED_SLOT_TABLE_LOOKUP_OR_ALLOCATE_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define KSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define KSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/ksl_pkg.sv */
// ----------------------------------------------------------------------------
// Keyed slot table package
// Beat types, request and status codes, and the token that walks the cells.
// ----------------------------------------------------------------------------
package ksl_pkg;

  localparam logic [15:0] FREE_KEY = 16'hFFFF;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_ALLOC   = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic [2:0] CFG_ADDR_ACTIVE = 3'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
  } rsp_t;

  // Request state handed from one cell to the next.
  typedef struct packed {
    logic        valid;
    logic [1:0]  req_type;
    logic [15:0] key;
    logic        found;
    logic        free_seen;
  } ksl_token_t;

endpackage

/* hw/rtl/ksl_cell.sv */
// ----------------------------------------------------------------------------
// Keyed slot table cell
// Holds one slot key, checks the passing request against it and forwards it.
// ----------------------------------------------------------------------------
module ksl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          active_slots_i,
  input  ksl_pkg::ksl_token_t tok_i,
  input  logic [IW-1:0]       found_idx_i,
  input  logic [IW-1:0]       free_idx_i,
  output ksl_pkg::ksl_token_t tok_o,
  output logic [IW-1:0]       found_idx_o,
  output logic [IW-1:0]       free_idx_o,
  input  logic                wr_en_i,
  input  logic [IW-1:0]       wr_idx_i,
  input  logic [15:0]         wr_key_i
);
  import ksl_pkg::*;

  logic        active;
  logic        hit;
  logic        is_free;
  logic [15:0] key_q, key_d;
  ksl_token_t  tok_q, tok_d;
  logic [IW-1:0] found_idx_q, found_idx_d;
  logic [IW-1:0] free_idx_q, free_idx_d;

  assign active  = IDX < 32'(active_slots_i);
  assign hit     = active && (tok_i.key != FREE_KEY) && (key_q == tok_i.key) && !tok_i.found;
  assign is_free = active && (key_q == FREE_KEY) && !tok_i.free_seen;

  always_comb begin
    tok_d           = tok_i;
    tok_d.found     = tok_i.found | hit;
    tok_d.free_seen = tok_i.free_seen | is_free;
    found_idx_d     = hit ? IW'(IDX) : found_idx_i;
    free_idx_d      = is_free ? IW'(IDX) : free_idx_i;

    key_d = key_q;
    if (tok_i.valid && (tok_i.req_type == REQ_REMOVE) && hit) begin
      key_d = FREE_KEY;
    end
    if (tok_i.valid && (tok_i.req_type == REQ_CLEAR) && active) begin
      key_d = FREE_KEY;
    end
    // Allocation is written back once the request has left the chain.
    if (wr_en_i && (wr_idx_i == IW'(IDX))) begin
      key_d = wr_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= FREE_KEY;
      tok_q <= '0;
    end else begin
      key_q <= key_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_idx_q <= found_idx_d;
    free_idx_q  <= free_idx_d;
  end

  assign tok_o       = tok_q;
  assign found_idx_o = found_idx_q;
  assign free_idx_o  = free_idx_q;

endmodule

/* hw/rtl/keyed_slot_table_lookup_or_allocate_core.sv */
// ----------------------------------------------------------------------------
// Keyed slot table lookup or allocate core
//
//   Channel   Signals                              Direction
//   in        in_valid_i / in_ready_o / in_data_i   request beat in
//   out       out_valid_o / out_ready_i / out_data_o result beat out
//   cfg       psel penable pwrite paddr pwdata ...  APB register port
//
// A request walks the row of slot cells one cell per cycle. A new request is
// taken only after the previous result has left the chain and reached the
// output register, so only one request is ever in the chain.
// An allocation is written back as the request leaves the last cell.
// Reset marks every slot free and sets active_slots to 16; no clearing pass.
// A stalled result waits in a hold register while the chain stays empty.
// ----------------------------------------------------------------------------
`include "keyed_slot_table_lookup_or_allocate_core_assert.svh"

module keyed_slot_table_lookup_or_allocate_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ksl_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ksl_pkg::rsp_t  out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ksl_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] active_q;
  rsp_t       out_q, out_d;
  logic       out_valid_q, out_valid_d;
  rsp_t       hold_q, hold_d;

  ksl_token_t    tok       [SLOTS+1];
  logic [IW-1:0] found_idx [SLOTS+1];
  logic [IW-1:0] free_idx  [SLOTS+1];
  logic [SLOTS-1:0] chain_valid;

  ksl_token_t    exit_tok;
  rsp_t          res;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [IW+3:0] found_ext, free_ext;
  logic          out_free;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 5'd16;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_ADDR_ACTIVE[2])) begin
      active_q <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == CFG_ADDR_ACTIVE[2]) ? {27'd0, active_q} : 32'd0;

  // Head of the chain.
  assign in_ready_o         = (state_q == S_IDLE);
  assign tok[0].valid       = in_valid_i && in_ready_o;
  assign tok[0].req_type    = in_data_i.req_type;
  assign tok[0].key         = in_data_i.key;
  assign tok[0].found       = 1'b0;
  assign tok[0].free_seen   = 1'b0;
  assign found_idx[0]       = '0;
  assign free_idx[0]        = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ksl_cell #(
      .IDX(g),
      .IW (IW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .active_slots_i(active_q),
      .tok_i         (tok[g]),
      .found_idx_i   (found_idx[g]),
      .free_idx_i    (free_idx[g]),
      .tok_o         (tok[g+1]),
      .found_idx_o   (found_idx[g+1]),
      .free_idx_o    (free_idx[g+1]),
      .wr_en_i       (wr_en),
      .wr_idx_i      (wr_idx),
      .wr_key_i      (exit_tok.key)
    );
    assign chain_valid[g] = tok[g+1].valid;
  end

  // Tail of the chain: form the result beat and the allocation write.
  assign exit_tok  = tok[SLOTS];
  assign found_ext = {4'd0, found_idx[SLOTS]};
  assign free_ext  = {4'd0, free_idx[SLOTS]};
  assign wr_idx    = free_idx[SLOTS];
  assign wr_en     = exit_tok.valid && (exit_tok.req_type == REQ_INSERT) &&
                     !exit_tok.found && exit_tok.free_seen && (exit_tok.key != FREE_KEY);

  always_comb begin
    res.status     = ST_MISS;
    res.slot_index = 4'd0;
    if (exit_tok.req_type == REQ_CLEAR) begin
      res.status = ST_CLEARED;
    end else if (exit_tok.found) begin
      res.status     = ST_HIT;
      res.slot_index = found_ext[3:0];
    end else if (exit_tok.req_type == REQ_INSERT && exit_tok.free_seen &&
                 exit_tok.key != FREE_KEY) begin
      res.status     = ST_ALLOC;
      res.slot_index = free_ext[3:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (tok[0].valid) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (exit_tok.valid) begin
          if (out_free) begin
            out_d       = res;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            hold_d  = res;
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KSL_ASSERT_IMP(a_one_token, clk_i, rst_ni, 1'b1, $onehot0(chain_valid), "two requests in chain")
  `KSL_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, in_ready_o, chain_valid == '0, "ready while busy")
  `KSL_ASSERT_NXT(a_exit_out, clk_i, rst_ni, exit_tok.valid, out_valid_o, "result not presented")

endmodule
